// ===== sv/apq_pkg.sv =====
// apq_pkg: request kind codes and fixed field widths for the array priority queue.
// No dependencies; used by array_priority_queue.
package apq_pkg;

  localparam int KIND_W     = 2;
  localparam int PRIO_IN_W  = 16;
  localparam int TAG_IO_W   = 32;
  localparam int COUNT_IO_W = 4;
  localparam int CAP_W      = 4;

  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXTRACT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

endpackage

// ===== sv/array_priority_queue.sv =====
// Bounded priority queue over an unsorted array in two 1R1W entry memories; uses apq_pkg.
// Requests are taken one at a time: req_stall_o holds off new requests until the result of
// the last one has been registered; extract scans all held entries over the memory read port
// and then shifts the entries above the winner down one place.
// A stalled result channel also holds the flow.
// Reset empties the queue and sets capacity to DEPTH (at most 15); memories stay unwritten.
module array_priority_queue #(
  parameter int DEPTH          = 8,
  parameter int PRIORITY_WIDTH = 16,
  parameter int TAG_WIDTH      = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [apq_pkg::CAP_W-1:0]        cfg_data_i,
  // request channel
  input  logic                             req_valid_i,
  output logic                             req_stall_o,
  input  logic [apq_pkg::KIND_W-1:0]       kind_i,
  input  logic [apq_pkg::PRIO_IN_W-1:0]    priority_req_i,
  input  logic [apq_pkg::TAG_IO_W-1:0]     payload_tag_i,
  // result channel
  output logic                             res_valid_o,
  input  logic                             res_stall_i,
  output logic [apq_pkg::TAG_IO_W-1:0]     out_tag_o,
  output logic                             out_valid_o,
  output logic                             dropped_o,
  output logic [apq_pkg::COUNT_IO_W-1:0]   entry_count_o,
  output logic                             is_empty_o,
  output logic                             is_full_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [apq_pkg::CAP_W-1:0] CAP_RST =
    apq_pkg::CAP_W'(DEPTH <= 15 ? DEPTH : 15);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_EMIT} state_e;

  state_e                               state_q, state_d;
  logic [CW-1:0]                        held_q, held_d;
  logic [apq_pkg::CAP_W-1:0]            cap_q, cap_d;
  logic [AW-1:0]                        ptr_q, ptr_d;
  logic [AW-1:0]                        best_idx_q, best_idx_d;
  logic signed [PRIORITY_WIDTH-1:0]     best_pri_q, best_pri_d;
  logic [TAG_WIDTH-1:0]                 best_tag_q, best_tag_d;
  logic                                 pend_hit_q, pend_hit_d;
  logic                                 pend_drop_q, pend_drop_d;
  logic                                 res_valid_q, res_valid_d;
  logic [apq_pkg::TAG_IO_W-1:0]         res_tag_q, res_tag_d;
  logic                                 res_hit_q, res_hit_d;
  logic                                 res_drop_q, res_drop_d;
  logic [apq_pkg::COUNT_IO_W-1:0]       res_count_q, res_count_d;
  logic                                 res_empty_q, res_empty_d;
  logic                                 res_full_q, res_full_d;

  // entry memories
  logic [TAG_WIDTH-1:0]                 tag_mem [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0]     pri_mem [DEPTH];
  logic                                 rd_en;
  logic [AW-1:0]                        rd_addr;
  logic [TAG_WIDTH-1:0]                 rd_tag_q;
  logic signed [PRIORITY_WIDTH-1:0]     rd_pri_q;
  logic                                 wr_en;
  logic [AW-1:0]                        wr_addr;
  logic [TAG_WIDTH-1:0]                 wr_tag;
  logic signed [PRIORITY_WIDTH-1:0]     wr_pri;

  logic [CW-1:0]                        cap_eff;
  logic [CW-1:0]                        last_idx;
  logic                                 req_beat;
  logic                                 take;

  assign req_stall_o = (state_q != S_IDLE);
  assign req_beat    = req_valid_i && !req_stall_o;
  assign last_idx    = held_q - CW'(1);

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (int'(cap_q) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  assign take = (ptr_q == '0) || (rd_pri_q > best_pri_q);

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    cap_d       = cap_q;
    ptr_d       = ptr_q;
    best_idx_d  = best_idx_q;
    best_pri_d  = best_pri_q;
    best_tag_d  = best_tag_q;
    pend_hit_d  = pend_hit_q;
    pend_drop_d = pend_drop_q;
    res_valid_d = res_valid_q && res_stall_i;
    res_tag_d   = res_tag_q;
    res_hit_d   = res_hit_q;
    res_drop_d  = res_drop_q;
    res_count_d = res_count_q;
    res_empty_d = res_empty_q;
    res_full_d  = res_full_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_tag      = rd_tag_q;
    wr_pri      = rd_pri_q;

    if (cfg_we_i) begin
      cap_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (req_beat) begin
          pend_hit_d  = 1'b0;
          pend_drop_d = 1'b0;
          state_d     = S_EMIT;
          case (kind_i)
            apq_pkg::KIND_ADD: begin
              if (held_q >= cap_eff) begin
                pend_drop_d = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = held_q[AW-1:0];
                wr_tag  = TAG_WIDTH'(payload_tag_i);
                wr_pri  = PRIORITY_WIDTH'($signed(priority_req_i));
                held_d  = held_q + CW'(1);
              end
            end
            apq_pkg::KIND_EXTRACT: begin
              if (held_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            apq_pkg::KIND_CLEAR: begin
              held_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (take) begin
          best_idx_d = ptr_q;
          best_pri_d = rd_pri_q;
          best_tag_d = rd_tag_q;
        end
        if (CW'(ptr_q) == last_idx) begin
          if (CW'(best_idx_d) == last_idx) begin
            held_d     = last_idx;
            pend_hit_d = 1'b1;
            state_d    = S_EMIT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(CW'(best_idx_d) + CW'(1));
            ptr_d   = best_idx_d;
            state_d = S_SHIFT;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(CW'(ptr_q) + CW'(1));
          ptr_d   = rd_addr;
        end
      end
      S_SHIFT: begin
        // entry ptr+1 arrives from the read port and moves down one place
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        if (CW'(ptr_q) + CW'(1) == last_idx) begin
          held_d     = last_idx;
          pend_hit_d = 1'b1;
          state_d    = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(CW'(ptr_q) + CW'(2));
          ptr_d   = AW'(CW'(ptr_q) + CW'(1));
        end
      end
      S_EMIT: begin
        if (!res_valid_q || !res_stall_i) begin
          res_valid_d = 1'b1;
          res_hit_d   = pend_hit_q;
          res_drop_d  = pend_drop_q;
          res_tag_d   = pend_hit_q ? apq_pkg::TAG_IO_W'(best_tag_q) : '0;
          res_count_d = apq_pkg::COUNT_IO_W'(held_q);
          res_empty_d = (held_q == '0);
          res_full_d  = (held_q >= cap_eff);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      cap_q       <= CAP_RST;
      ptr_q       <= '0;
      best_idx_q  <= '0;
      pend_hit_q  <= 1'b0;
      pend_drop_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      cap_q       <= cap_d;
      ptr_q       <= ptr_d;
      best_idx_q  <= best_idx_d;
      pend_hit_q  <= pend_hit_d;
      pend_drop_q <= pend_drop_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_pri_q  <= best_pri_d;
    best_tag_q  <= best_tag_d;
    res_tag_q   <= res_tag_d;
    res_hit_q   <= res_hit_d;
    res_drop_q  <= res_drop_d;
    res_count_q <= res_count_d;
    res_empty_q <= res_empty_d;
    res_full_q  <= res_full_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_tag;
      pri_mem[wr_addr] <= wr_pri;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_tag_q <= tag_mem[rd_addr];
      rd_pri_q <= pri_mem[rd_addr];
    end
  end

  assign res_valid_o   = res_valid_q;
  assign out_tag_o     = res_tag_q;
  assign out_valid_o   = res_hit_q;
  assign dropped_o     = res_drop_q;
  assign entry_count_o = res_count_q;
  assign is_empty_o    = res_empty_q;
  assign is_full_o     = res_full_q;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(held_q) <= DEPTH)
    else $error("held count above depth");

  a_hit_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && out_valid_o) |-> !dropped_o)
    else $error("result both hit and dropped");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (CW'(ptr_q) + CW'(1) <= last_idx))
    else $error("shift pointer past held entries");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_beat && kind_i == apq_pkg::KIND_ADD && held_q < cap_eff)
      |=> (held_q == CW'($past(held_q) + CW'(1))))
    else $error("accepted add did not grow the queue");
`endif

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for array_priority_queue. A directed table is followed by
// random requests over several capacity settings, checked beat by beat against a queue model.
// Depends on apq_pkg and array_priority_queue.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 196;
  localparam int PLAN_ROWS = 26;
  localparam int LONG_HOLD = 300;
  localparam logic [apq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [apq_pkg::TAG_IO_W-1:0]   tag;
    logic                           hit;
    logic                           drop;
    logic [apq_pkg::COUNT_IO_W-1:0] count;
    logic                           empty;
    logic                           full;
  } result_t;

  typedef struct packed {
    logic [apq_pkg::KIND_W-1:0]    kind;
    logic [apq_pkg::PRIO_IN_W-1:0] prio;
    logic [apq_pkg::TAG_IO_W-1:0]  tag;
    logic                          typed;
    result_t                       want;
  } row_t;

  localparam result_t NO_WANT = '0;
  localparam result_t EMPTY_STATUS = '{32'h0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0};

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [apq_pkg::CAP_W-1:0]      cfg_data_i;
  logic                           req_valid_i;
  logic                           req_stall_o;
  logic [apq_pkg::KIND_W-1:0]     kind_i;
  logic [apq_pkg::PRIO_IN_W-1:0]  priority_req_i;
  logic [apq_pkg::TAG_IO_W-1:0]   payload_tag_i;
  logic                           res_valid_o;
  logic                           res_stall_i;
  logic [apq_pkg::TAG_IO_W-1:0]   out_tag_o;
  logic                           out_valid_o;
  logic                           dropped_o;
  logic [apq_pkg::COUNT_IO_W-1:0] entry_count_o;
  logic                           is_empty_o;
  logic                           is_full_o;

  array_priority_queue #(
    .DEPTH         (QDEPTH),
    .PRIORITY_WIDTH(16),
    .TAG_WIDTH     (32)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .req_valid_i   (req_valid_i),
    .req_stall_o   (req_stall_o),
    .kind_i        (kind_i),
    .priority_req_i(priority_req_i),
    .payload_tag_i (payload_tag_i),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .out_tag_o     (out_tag_o),
    .out_valid_o   (out_valid_o),
    .dropped_o     (dropped_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  // queue model state
  logic [apq_pkg::TAG_IO_W-1:0]         held_tags [QDEPTH];
  logic signed [apq_pkg::PRIO_IN_W-1:0] held_prios [QDEPTH];
  int unsigned                          held_n;
  logic [apq_pkg::CAP_W-1:0]            cap_setting;

  result_t     pending_results [$];
  row_t        plan [PLAN_ROWS];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned errors;
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_hits;
  int unsigned n_drops;

  function automatic result_t serve_request(input logic [apq_pkg::KIND_W-1:0] k,
                                            input logic signed [apq_pkg::PRIO_IN_W-1:0] p,
                                            input logic [apq_pkg::TAG_IO_W-1:0] t);
    result_t     o;
    int unsigned lim;
    int unsigned best;
    o = '0;
    lim = (cap_setting == 0) ? 1 : ((cap_setting > QDEPTH) ? QDEPTH : cap_setting);
    case (k)
      apq_pkg::KIND_ADD: begin
        if (held_n >= lim) begin
          o.drop = 1'b1;
        end else begin
          held_tags[held_n] = t;
          held_prios[held_n] = p;
          held_n++;
        end
      end
      apq_pkg::KIND_EXTRACT: begin
        if (held_n > 0) begin
          best = 0;
          for (int i = 1; i < held_n; i++) begin
            if (held_prios[i] > held_prios[best]) best = i;
          end
          o.tag = held_tags[best];
          o.hit = 1'b1;
          for (int i = best; i + 1 < held_n; i++) begin
            held_tags[i] = held_tags[i+1];
            held_prios[i] = held_prios[i+1];
          end
          held_n--;
        end
      end
      apq_pkg::KIND_CLEAR: held_n = 0;
      default: ;
    endcase
    o.count = held_n[apq_pkg::COUNT_IO_W-1:0];
    o.empty = (held_n == 0);
    o.full = (held_n >= lim);
    return o;
  endfunction

  task automatic offer_beat(input logic [apq_pkg::KIND_W-1:0] k,
                            input logic [apq_pkg::PRIO_IN_W-1:0] p,
                            input logic [apq_pkg::TAG_IO_W-1:0] t, input logic typed,
                            input result_t want);
    result_t modeled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    kind_i <= k;
    priority_req_i <= p;
    payload_tag_i <= t;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    modeled = serve_request(k, p, t);
    pending_results.push_back(typed ? want : modeled);
    n_items++;
  endtask

  task automatic drain_results();
    req_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [apq_pkg::CAP_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_setting = value;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    res_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res_stall_i <= 1'b1;
        hold_left--;
      end else begin
        res_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    result_t act_r;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      act_r = '{out_tag_o, out_valid_o, dropped_o, entry_count_o, is_empty_o, is_full_o};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: tag=%h count=%0d",
                                   out_tag_o, entry_count_o);
      end else begin
        exp_r = pending_results.pop_front();
        n_results++;
        if (exp_r.hit) n_hits++;
        if (exp_r.drop) n_drops++;
        if (act_r !== exp_r) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at result %0d", n_results);
            $display("  exp tag=%h valid=%b drop=%b count=%0d empty=%b full=%b",
                     exp_r.tag, exp_r.hit, exp_r.drop, exp_r.count, exp_r.empty,
                     exp_r.full);
            $display("  got tag=%h valid=%b drop=%b count=%0d empty=%b full=%b",
                     act_r.tag, act_r.hit, act_r.drop, act_r.count, act_r.empty, act_r.full);
          end
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_valid_i && !req_stall_o) || (res_valid_o && !res_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles, %0d results outstanding", WATCHDOG_LIMIT,
             pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [apq_pkg::CAP_W-1:0]     caps [PHASES];
    int unsigned                   pick;
    logic [apq_pkg::KIND_W-1:0]    k;
    logic [apq_pkg::PRIO_IN_W-1:0] p;

    plan = '{
      '{apq_pkg::KIND_EXTRACT, 16'h0000, 32'h00000000, 1'b1, EMPTY_STATUS},
      '{KIND_UNUSED, 16'h7FFF, 32'hFFFFFFFF, 1'b1, EMPTY_STATUS},
      '{apq_pkg::KIND_CLEAR, 16'h0000, 32'h00000000, 1'b1, EMPTY_STATUS},
      '{apq_pkg::KIND_ADD, 16'h8000, 32'hFFFFFFFF, 1'b1, '{32'h0, 1'b0, 1'b0, 4'd1, 1'b0, 1'b0}},
      '{apq_pkg::KIND_ADD, 16'h7FFF, 32'h00000000, 1'b1, '{32'h0, 1'b0, 1'b0, 4'd2, 1'b0, 1'b0}},
      '{apq_pkg::KIND_ADD, 16'h0000, 32'h55555555, 1'b0, NO_WANT},
      '{apq_pkg::KIND_ADD, 16'h7FFF, 32'hAAAAAAAA, 1'b0, NO_WANT},
      '{apq_pkg::KIND_ADD, 16'hFFFF, 32'h00000001, 1'b0, NO_WANT},
      '{apq_pkg::KIND_ADD, 16'h0001, 32'h00000002, 1'b0, NO_WANT},
      '{apq_pkg::KIND_ADD, 16'h8000, 32'h00000003, 1'b0, NO_WANT},
      '{apq_pkg::KIND_ADD, 16'h7FFE, 32'h00000004, 1'b1, '{32'h0, 1'b0, 1'b0, 4'd8, 1'b0, 1'b1}},
      '{apq_pkg::KIND_ADD, 16'h7FFF, 32'hDEADBEEF, 1'b1, '{32'h0, 1'b0, 1'b1, 4'd8, 1'b0, 1'b1}},
      '{apq_pkg::KIND_EXTRACT, 16'h0000, 32'h00000000, 1'b0, NO_WANT},
      '{apq_pkg::KIND_EXTRACT, 16'h1234, 32'h12345678, 1'b0, NO_WANT},
      '{apq_pkg::KIND_EXTRACT, 16'h0000, 32'h00000000, 1'b0, NO_WANT},
      '{KIND_UNUSED, 16'hFFFF, 32'hFFFFFFFF, 1'b0, NO_WANT},
      '{apq_pkg::KIND_EXTRACT, 16'h0000, 32'h00000000, 1'b0, NO_WANT},
      '{apq_pkg::KIND_EXTRACT, 16'h0000, 32'h00000000, 1'b0, NO_WANT},
      '{apq_pkg::KIND_EXTRACT, 16'h0000, 32'h00000000, 1'b0, NO_WANT},
      '{apq_pkg::KIND_EXTRACT, 16'h0000, 32'h00000000, 1'b0, NO_WANT},
      '{apq_pkg::KIND_EXTRACT, 16'h0000, 32'h00000000, 1'b0, NO_WANT},
      '{apq_pkg::KIND_ADD, 16'h0000, 32'h00000000, 1'b0, NO_WANT},
      '{apq_pkg::KIND_CLEAR, 16'hFFFF, 32'hFFFFFFFF, 1'b1, EMPTY_STATUS},
      '{apq_pkg::KIND_ADD, 16'h1234, 32'h0F0F0F0F, 1'b0, NO_WANT},
      '{apq_pkg::KIND_ADD, 16'h8001, 32'hF0F0F0F0, 1'b0, NO_WANT},
      '{apq_pkg::KIND_ADD, 16'h7FFF, 32'h80000001, 1'b0, NO_WANT}
    };
    // first setting sits below the three entries left by the table
    caps = '{4'd2, 4'd0, 4'd15, 4'd1, 4'd8, apq_pkg::CAP_W'($urandom_range(3, 7)),
             apq_pkg::CAP_W'($urandom_range(0, 15))};

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    req_valid_i <= 1'b0;
    kind_i <= apq_pkg::KIND_ADD;
    priority_req_i <= '0;
    payload_tag_i <= '0;
    hold_left = 0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_hits = 0;
    n_drops = 0;
    held_n = 0;
    cap_setting = apq_pkg::CAP_W'(QDEPTH);
    send_idle_pct = 27;
    recv_idle_pct = 62;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      offer_beat(plan[r].kind, plan[r].prio, plan[r].tag, plan[r].typed, plan[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(caps[ph]);
      send_idle_pct = (ph < 3) ? 27 : ((ph < 5) ? 62 : 0);
      recv_idle_pct = (ph < 3) ? 62 : ((ph < 5) ? 27 : 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 40) hold_left = LONG_HOLD;
        if (ph == 2 && n == 100) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 58) k = apq_pkg::KIND_ADD;
        else if (pick < 96) k = apq_pkg::KIND_EXTRACT;
        else if (pick < 98) k = apq_pkg::KIND_CLEAR;
        else k = KIND_UNUSED;
        case ($urandom_range(0, 3))
          0: p = apq_pkg::PRIO_IN_W'($urandom_range(0, 3)) - 16'd2;
          1: begin
            case ($urandom_range(0, 3))
              0: p = 16'h7FFF;
              1: p = 16'h8000;
              2: p = 16'h0000;
              default: p = 16'hFFFF;
            endcase
          end
          default: p = apq_pkg::PRIO_IN_W'($urandom);
        endcase
        offer_beat(k, p, $urandom, 1'b0, NO_WANT);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("run covered %0d requests and %0d results over %0d capacity settings",
             n_items, n_results, PHASES + 1);
    $display("extracts returning an entry: %0d, refused adds: %0d, mismatches: %0d",
             n_hits, n_drops, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/apq_pkg.sv
sv/array_priority_queue.sv
verif/tb_top.sv
